### rtl/region_bump_allocator_table_top_assert.svh
// assertion macros used by the allocator datapath
`ifndef REGION_BUMP_ALLOCATOR_TABLE_TOP_ASSERT_SVH
`define REGION_BUMP_ALLOCATOR_TABLE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RATB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// next-cycle implication
`define RATB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

### rtl/ratb_pkg.sv
// shared types, codes and constants of the region allocator
package ratb_pkg;

	localparam int WIDE_W = 64;

	localparam logic [63:0] SPACE_MIN_RST = 64'h7100_0000_0000_0000;
	localparam logic [63:0] SPACE_LIM_RST = 64'h7200_0000_0000_0000;
	localparam logic [5:0]  MAX_BITS_RST  = 6'd48;

	localparam logic [1:0] CFG_SPACE_MIN = 2'd0;
	localparam logic [1:0] CFG_SPACE_LIM = 2'd1;
	localparam logic [1:0] CFG_MAX_BITS  = 2'd2;

	typedef enum logic [1:0] {
		KIND_CREATE   = 2'd0,
		KIND_CHECK    = 2'd1,
		KIND_CLASSIFY = 2'd2
	} kind_e;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EXISTS    = 3'd1,
		ST_NO_ROOM   = 3'd2,
		ST_FULL      = 3'd3,
		ST_OUTSIDE   = 3'd4,
		ST_NO_REGION = 3'd5
	} status_e;

	typedef enum logic [1:0] {
		RES_BARE      = 2'd0,
		RES_ENTRY     = 2'd1,
		RES_ENTRY_OFF = 2'd2
	} res_mode_e;

	typedef enum logic [2:0] {
		S_IDLE   = 3'd0,
		S_CHOOSE = 3'd1,
		S_SCAN   = 3'd2,
		S_ALLOC  = 3'd3,
		S_FINISH = 3'd4
	} state_e;

	typedef struct packed {
		logic      capture;
		logic      issue;
		logic      take_hit;
		logic      alloc;
		logic      load_out;
		status_e   status;
		res_mode_e mode;
	} ratb_cmd_t;

	typedef struct packed {
		kind_e kind;
		logic  outside;
		logic  fits;
		logic  full;
		logic  match;
		logic  pending;
		logic  issue_done;
		logic  out_free;
	} ratb_stat_t;

	function automatic logic [WIDE_W-1:0] span_of(input logic [5:0] b);
		return {{(WIDE_W-1){1'b0}}, 1'b1} << b;
	endfunction

endpackage

### rtl/region_bump_allocator_table_top.sv
// top level of the region bump allocator with its region table
//
// One item is worked on at a time. A check item goes from accept through the
// choose state to the result; a create item, or a classify item whose address
// lies inside the space, walks the region table through the single read port
// of the table ram, one entry per cycle (a create that allocates then writes
// the new entry in the alloc state). The scan stops at the first matching
// entry. The result sits in an output register, so a new item is taken while
// it waits. Writing space_min also reloads the bump pointer; the user must write
// configuration only while no item is in flight; the block does not enforce it.
module region_bump_allocator_table_top #(
	parameter int MAX_REGIONS = 256,
	parameter int ADDR_BITS   = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// size_bits[5:0], type_tag[13:6], address[ADDR_BITS+13:14], zero pad
	input  logic [((14+ADDR_BITS+7)/8)*8-1:0]      s_tdata,
	// kind[1:0]
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// region_index, base_address, end_address, region_bits, offset, region_tag, zero pad
	output logic [((22+3*ADDR_BITS+7)/8)*8-1:0]    m_tdata,
	// status[2:0]
	output logic [2:0]           m_tuser,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [ADDR_BITS-1:0] cfg_data
);

	localparam int OUT_W = ((22 + 3 * ADDR_BITS + 7) / 8) * 8;
	localparam int PAY_W = 22 + 3 * ADDR_BITS;

	ratb_pkg::ratb_cmd_t  cmd;
	ratb_pkg::ratb_stat_t stat;

	logic [7:0]           region_index;
	logic [ADDR_BITS-1:0] base_address, end_address, offset;
	logic [5:0]           region_bits;
	logic [7:0]           region_tag;
	logic [PAY_W-1:0]     payload;

	ratb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ratb_dp #(
		.MAX_REGIONS (MAX_REGIONS),
		.ADDR_BITS   (ADDR_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_kind          (s_tuser),
		.in_size_bits     (s_tdata[5:0]),
		.in_type_tag      (s_tdata[13:6]),
		.in_address       (s_tdata[ADDR_BITS+13:14]),
		.cmd              (cmd),
		.stat             (stat),
		.m_tready         (m_tready),
		.m_tvalid         (m_tvalid),
		.out_status       (m_tuser),
		.out_region_index (region_index),
		.out_base_address (base_address),
		.out_end_address  (end_address),
		.out_region_bits  (region_bits),
		.out_offset       (offset),
		.out_region_tag   (region_tag)
	);

	assign payload = {region_tag, offset, region_bits, end_address, base_address,
		region_index};
	assign m_tdata = OUT_W'(payload);

endmodule

### rtl/ratb_ram.sv
// generic single-port-write ram with registered read
module ratb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/ratb_ctrl.sv
// controller state machine: sequences scan, allocation and result hand-off
module ratb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  ratb_pkg::ratb_stat_t stat,
	output ratb_pkg::ratb_cmd_t  cmd
);

	ratb_pkg::state_e    state_q, state_d;
	ratb_pkg::status_e   res_status_q, res_status_d;
	ratb_pkg::res_mode_e res_mode_q, res_mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ratb_pkg::S_IDLE;
			res_status_q <= ratb_pkg::ST_OK;
			res_mode_q   <= ratb_pkg::RES_BARE;
		end else begin
			state_q      <= state_d;
			res_status_q <= res_status_d;
			res_mode_q   <= res_mode_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		res_status_d = res_status_q;
		res_mode_d   = res_mode_q;
		s_tready     = 1'b0;
		cmd          = '0;
		cmd.status   = res_status_q;
		cmd.mode     = res_mode_q;
		case (state_q)
			ratb_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ratb_pkg::S_CHOOSE;
				end
			end
			ratb_pkg::S_CHOOSE: begin
				res_mode_d = ratb_pkg::RES_BARE;
				state_d    = ratb_pkg::S_FINISH;
				case (stat.kind)
					ratb_pkg::KIND_CREATE: begin
						state_d = ratb_pkg::S_SCAN;
					end
					ratb_pkg::KIND_CHECK: begin
						res_status_d = stat.fits ? ratb_pkg::ST_OK : ratb_pkg::ST_NO_ROOM;
					end
					ratb_pkg::KIND_CLASSIFY: begin
						if (stat.outside) begin
							res_status_d = ratb_pkg::ST_OUTSIDE;
						end else begin
							state_d = ratb_pkg::S_SCAN;
						end
					end
					default: begin
						res_status_d = ratb_pkg::ST_NO_REGION;
					end
				endcase
			end
			ratb_pkg::S_SCAN: begin
				cmd.issue = !stat.match;
				if (stat.match) begin
					cmd.take_hit = 1'b1;
					state_d      = ratb_pkg::S_FINISH;
					if (stat.kind == ratb_pkg::KIND_CREATE) begin
						res_status_d = ratb_pkg::ST_EXISTS;
						res_mode_d   = ratb_pkg::RES_ENTRY;
					end else begin
						res_status_d = ratb_pkg::ST_OK;
						res_mode_d   = ratb_pkg::RES_ENTRY_OFF;
					end
				end else if (stat.issue_done && !stat.pending) begin
					res_mode_d = ratb_pkg::RES_BARE;
					state_d    = ratb_pkg::S_FINISH;
					if (stat.kind != ratb_pkg::KIND_CREATE) begin
						res_status_d = ratb_pkg::ST_NO_REGION;
					end else if (!stat.fits) begin
						res_status_d = ratb_pkg::ST_NO_ROOM;
					end else if (stat.full) begin
						res_status_d = ratb_pkg::ST_FULL;
					end else begin
						state_d = ratb_pkg::S_ALLOC;
					end
				end
			end
			ratb_pkg::S_ALLOC: begin
				cmd.alloc    = 1'b1;
				res_status_d = ratb_pkg::ST_OK;
				res_mode_d   = ratb_pkg::RES_ENTRY;
				state_d      = ratb_pkg::S_FINISH;
			end
			ratb_pkg::S_FINISH: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ratb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ratb_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### rtl/ratb_dp.sv
// datapath: window registers, bump pointer, region table scan and result register
`include "region_bump_allocator_table_top_assert.svh"

module ratb_dp #(
	parameter int MAX_REGIONS = 256,
	parameter int ADDR_BITS   = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [ADDR_BITS-1:0] cfg_data,
	input  logic [1:0]           in_kind,
	input  logic [5:0]           in_size_bits,
	input  logic [7:0]           in_type_tag,
	input  logic [ADDR_BITS-1:0] in_address,
	input  ratb_pkg::ratb_cmd_t  cmd,
	output ratb_pkg::ratb_stat_t stat,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [2:0]           out_status,
	output logic [7:0]           out_region_index,
	output logic [ADDR_BITS-1:0] out_base_address,
	output logic [ADDR_BITS-1:0] out_end_address,
	output logic [5:0]           out_region_bits,
	output logic [ADDR_BITS-1:0] out_offset,
	output logic [7:0]           out_region_tag
);

	localparam int IDX_W  = $clog2(MAX_REGIONS);
	localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
	localparam int PAD_W  = ratb_pkg::WIDE_W - ADDR_BITS;
	localparam int WORD_W = ADDR_BITS + 14;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

	logic [ADDR_BITS-1:0] space_min_q, space_lim_q, bump_q;
	logic [5:0]           max_bits_q;
	logic [CNT_W-1:0]     count_q;

	ratb_pkg::kind_e      kind_q;
	logic [5:0]           bits_q;
	logic [7:0]           tag_q;
	logic [ADDR_BITS-1:0] addr_q;

	logic [CNT_W-1:0]     rd_idx_q;
	logic                 pend_s1;
	logic [IDX_W-1:0]     idx_s1;

	logic [IDX_W-1:0]     hit_idx_q;
	logic [ADDR_BITS-1:0] hit_base_q;
	logic [5:0]           hit_bits_q;
	logic [7:0]           hit_tag_q;

	logic                 out_valid_q;

	logic [WORD_W-1:0]    rd_word, wr_word;
	logic [ADDR_BITS-1:0] rd_base;
	logic [5:0]           rd_bits;
	logic [7:0]           rd_tag;
	logic [ratb_pkg::WIDE_W-1:0] rd_end_w, addr_w, rd_base_w, bump_sum_w, hit_end_w;
	logic                 issue_eff, in_range, match;
	logic [31:0]          hit_idx_ext;
	logic [CNT_W-1:0]     idx_s1_w;

	assign issue_eff = cmd.issue && (rd_idx_q < count_q);
	assign wr_word   = {tag_q, bits_q, bump_q};

	ratb_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_REGIONS)
	) u_table (
		.clk   (clk),
		.we    (cmd.alloc),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wr_word),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rd_word)
	);

	assign rd_base   = rd_word[ADDR_BITS-1:0];
	assign rd_bits   = rd_word[ADDR_BITS+5:ADDR_BITS];
	assign rd_tag    = rd_word[ADDR_BITS+13:ADDR_BITS+6];
	assign addr_w    = {{PAD_W{1'b0}}, addr_q};
	assign rd_base_w = {{PAD_W{1'b0}}, rd_base};
	assign rd_end_w  = rd_base_w + ratb_pkg::span_of(rd_bits);
	assign in_range  = (addr_w >= rd_base_w) && (addr_w < rd_end_w);
	assign match     = pend_s1 &&
		((kind_q == ratb_pkg::KIND_CREATE) ? (rd_tag == tag_q) : in_range);

	// bump + 2^bits never wraps in 64 bits since bump stays below 2^63
	assign bump_sum_w = {{PAD_W{1'b0}}, bump_q} + ratb_pkg::span_of(bits_q);

	assign stat.kind       = kind_q;
	assign stat.outside    = (addr_q < space_min_q) || (addr_q >= space_lim_q);
	assign stat.fits       = (bits_q <= max_bits_q) &&
		(bump_sum_w <= {{PAD_W{1'b0}}, space_lim_q});
	assign stat.full       = (count_q == CNT_MAX);
	assign stat.match      = match;
	assign stat.pending    = pend_s1;
	assign stat.issue_done = (rd_idx_q >= count_q);
	assign stat.out_free   = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_min_q <= ratb_pkg::SPACE_MIN_RST[ADDR_BITS-1:0];
			space_lim_q <= ratb_pkg::SPACE_LIM_RST[ADDR_BITS-1:0];
			max_bits_q  <= ratb_pkg::MAX_BITS_RST;
			bump_q      <= ratb_pkg::SPACE_MIN_RST[ADDR_BITS-1:0];
			count_q     <= '0;
			rd_idx_q    <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ratb_pkg::CFG_SPACE_MIN: begin
						space_min_q <= cfg_data;
						bump_q      <= cfg_data;
					end
					ratb_pkg::CFG_SPACE_LIM: begin
						space_lim_q <= cfg_data;
					end
					ratb_pkg::CFG_MAX_BITS: begin
						max_bits_q <= cfg_data[5:0];
					end
					default: begin
					end
				endcase
			end else if (cmd.alloc) begin
				bump_q <= bump_sum_w[ADDR_BITS-1:0];
			end
			if (cmd.alloc) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.capture) begin
				rd_idx_q <= '0;
			end else if (issue_eff) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			pend_s1 <= issue_eff;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= ratb_pkg::kind_e'(in_kind);
			bits_q <= in_size_bits;
			tag_q  <= in_type_tag;
			addr_q <= in_address;
		end
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (cmd.take_hit) begin
			hit_idx_q  <= idx_s1;
			hit_base_q <= rd_base;
			hit_bits_q <= rd_bits;
			hit_tag_q  <= rd_tag;
		end else if (cmd.alloc) begin
			hit_idx_q  <= count_q[IDX_W-1:0];
			hit_base_q <= bump_q;
			hit_bits_q <= bits_q;
			hit_tag_q  <= tag_q;
		end
	end

	assign hit_idx_ext = {{(32-IDX_W){1'b0}}, hit_idx_q};
	assign hit_end_w   = {{PAD_W{1'b0}}, hit_base_q} + ratb_pkg::span_of(hit_bits_q);
	assign idx_s1_w    = CNT_W'(idx_s1);

	// result register, fields beyond status are zero for a bare status
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status <= cmd.status;
			if (cmd.mode == ratb_pkg::RES_BARE) begin
				out_region_index <= '0;
				out_base_address <= '0;
				out_end_address  <= '0;
				out_region_bits  <= '0;
				out_offset       <= '0;
				out_region_tag   <= '0;
			end else begin
				out_region_index <= hit_idx_ext[7:0];
				out_base_address <= hit_base_q;
				out_end_address  <= hit_end_w[ADDR_BITS-1:0];
				out_region_bits  <= hit_bits_q;
				out_offset       <= (cmd.mode == ratb_pkg::RES_ENTRY_OFF) ?
					(addr_q - hit_base_q) : '0;
				out_region_tag   <= hit_tag_q;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	`RATB_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_MAX)
	`RATB_ASSERT_NOW(a_alloc_room, cmd.alloc, count_q < CNT_MAX)
	`RATB_ASSERT_NEXT(a_alloc_count, cmd.alloc, count_q == $past(count_q) + 1'b1)
	`RATB_ASSERT_NOW(a_read_written, pend_s1, idx_s1_w < count_q)
	`RATB_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid_q || m_tready)

endmodule
